// File: src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, skipped while reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// States that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// File: src/bfdh_pkg.sv
package bfdh_pkg;

  localparam int STORE_BITS_DEF  = 4096;
  localparam int KEY_W           = 32;
  localparam int ACTION_W        = 2;
  localparam int FILTER_BITS_W   = 13;
  localparam int PROBES_W        = 5;
  localparam int CFG_DATA_W      = 13;
  localparam int CFG_IDX_W       = 1;
  localparam int FILTER_BITS_RST = 64;
  localparam int PROBES_RST      = 6;
  localparam int MAX_PROBES      = 30;
  localparam int ROT_RIGHT       = 17;
  localparam int ROWS_LG_MAX     = 7;
  localparam int ROW_LG_MIN      = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_BITS = 1'b0,
    REG_PROBES      = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD_H,
    ST_MOD_D,
    ST_MOD_W,
    ST_PRB_RD,
    ST_PRB_CHK,
    ST_PRB_ADJ,
    ST_RESP
  } state_e;

  // Log2 of the row width of the bit store: the store keeps at most 128 rows.
  function automatic int row_lg(int store_bits);
    int lg;
    lg = $clog2(store_bits) - ROWS_LG_MAX;
    return (lg < ROW_LG_MIN) ? ROW_LG_MIN : lg;
  endfunction

  // Width of a filter size, bounded by both the store and the register.
  function automatic int size_w(int store_bits);
    int cap;
    cap = (store_bits < (2 ** FILTER_BITS_W) - 1) ? store_bits : (2 ** FILTER_BITS_W) - 1;
    return $clog2(cap + 1);
  endfunction

endpackage

// File: src/bfdh_rem_unit.sv
`include "assert_macros.svh"

module bfdh_rem_unit #(
  parameter int SizeW = bfdh_pkg::size_w(bfdh_pkg::STORE_BITS_DEF)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bfdh_pkg::KEY_W-1:0] dividend_i,
  input  logic [SizeW-1:0]           divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [SizeW-1:0]           rem_o
);
  import bfdh_pkg::*;

  localparam int CntW = $clog2(KEY_W);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [KEY_W-1:0] dvd_q;
  logic [SizeW-1:0] rem_q, rem_d;
  logic [SizeW:0]   trial;

  // Restoring remainder, one dividend bit per cycle, most significant first.
  always_comb begin
    trial = {rem_q, dvd_q[KEY_W-1]};
    if (trial >= {1'b0, divisor_i}) begin
      trial = trial - {1'b0, divisor_i};
    end
    rem_d = trial[SizeW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(KEY_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: src/bfdh_store.sv
module bfdh_store #(
  parameter int StoreBits = bfdh_pkg::STORE_BITS_DEF,
  parameter int RowLg     = bfdh_pkg::row_lg(StoreBits),
  parameter int RowW      = 1 << RowLg,
  parameter int Rows      = (StoreBits + RowW - 1) >> RowLg,
  parameter int RowAw     = $clog2(Rows)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             rd_en_i,
  input  logic [RowAw-1:0] rd_addr_i,
  output logic [RowW-1:0]  rd_data_o,
  input  logic             wr_en_i,
  input  logic [RowAw-1:0] wr_addr_i,
  input  logic [RowW-1:0]  wr_data_i
);
  import bfdh_pkg::*;

  logic [RowW-1:0] mem_q [Rows];
  logic [RowW-1:0] rd_row_q;
  logic [Rows-1:0] valid_q;
  logic            rd_valid_q;

  // A row that has not been written since reset or the last clear reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_row_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_row_q : '0;

endmodule

// File: src/bloom_filter_double_hash.sv
// Bloom filter over an on-chip bit store, probed by double hashing.
// Input channel (in_valid_i/in_ready_o) carries an action and a 32-bit key
// hash. Clear zeroes the store in the accept cycle. Insert sets the probed
// bits; query returns one may_match item on the output channel
// (out_valid_o/out_ready_i). Clear, insert and the unused action give no item.
// The block takes one item at a time. An insert or query with a usable probe
// count and a nonzero size runs three remainder passes of the shared bit-serial
// unit (key hash, probe step and 2^32, each modulo the filter size) and then,
// per probe, a read and a check/update step, with a wrap correction step between
// probes. A query that needs no probing goes straight to the response state.
// The user must write configuration through cfg_we_i/cfg_idx_i/cfg_data_i only
// while the block is idle; the block itself does not enforce it.
// Reset empties the store at once (each row carries a valid bit) and loads
// filter_bits = 64 and probes = 6. A stalled receiver holds the result in the
// output register; further items can be accepted meanwhile, and the next
// query result waits in the sequencer until the register frees up.
`include "assert_macros.svh"

module bloom_filter_double_hash #(
  parameter int STORE_BITS = bfdh_pkg::STORE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bfdh_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bfdh_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [bfdh_pkg::ACTION_W-1:0]      action_i,
  input  logic [bfdh_pkg::KEY_W-1:0]         key_hash_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               may_match_o
);
  import bfdh_pkg::*;

  localparam int SzW   = size_w(STORE_BITS);
  localparam int RowLg = row_lg(STORE_BITS);
  localparam int RowW  = 1 << RowLg;
  localparam int Rows  = (STORE_BITS + RowW - 1) >> RowLg;
  localparam int RowAw = $clog2(Rows);

  state_e state_q, state_d;

  logic [FILTER_BITS_W-1:0] filter_bits_q;
  logic [PROBES_W-1:0]      probes_q;

  logic [KEY_W-1:0] h_q, d_q;
  action_e          act_q, act_in;
  logic [SzW-1:0]   size_q, size_in;
  logic [SzW-1:0]   r_q, dm_q, wm_q;
  logic [PROBES_W-1:0] cnt_q;
  logic             carry_q, hit_q;
  logic             out_valid_q, may_match_q;

  logic             in_acc, probe_run, last_probe, bit_hit;
  logic [KEY_W:0]   h_sum;
  logic [SzW:0]     step_sum, step_r, wrap_r, wm_inc;
  logic [SzW-1:0]   wm_fix;
  logic [RowLg-1:0] bit_off;

  logic             rem_start, rem_busy, rem_done;
  logic [KEY_W-1:0] rem_dividend;
  logic [SzW-1:0]   rem;

  logic             st_clear, st_rd_en, st_wr_en;
  logic [RowAw-1:0] row_addr;
  logic [RowW-1:0]  st_rd_data, st_wr_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_bits_q <= FILTER_BITS_W'(FILTER_BITS_RST);
      probes_q      <= PROBES_W'(PROBES_RST);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FILTER_BITS: filter_bits_q <= cfg_data_i[FILTER_BITS_W-1:0];
        REG_PROBES:      probes_q      <= cfg_data_i[PROBES_W-1:0];
        default:         ;
      endcase
    end
  end

  assign in_acc    = in_valid_i && in_ready_o;
  assign act_in    = action_e'(action_i);
  assign size_in   = (32'(filter_bits_q) > 32'(STORE_BITS)) ? SzW'(STORE_BITS)
                                                             : SzW'(filter_bits_q);
  assign probe_run = (probes_q != '0) && (probes_q <= PROBES_W'(MAX_PROBES));
  assign last_probe = (cnt_q + 1'b1) == probes_q;

  assign bit_off  = r_q[RowLg-1:0];
  assign row_addr = RowAw'(r_q >> RowLg);
  assign bit_hit  = st_rd_data[bit_off];

  // Next probe: add the step modulo the size, then undo any 2^32 wrap.
  assign h_sum    = {1'b0, h_q} + {1'b0, d_q};
  assign step_sum = {1'b0, r_q} + {1'b0, dm_q};
  assign step_r   = (step_sum >= {1'b0, size_q}) ? step_sum - {1'b0, size_q} : step_sum;
  assign wrap_r   = (r_q >= wm_q) ? {1'b0, r_q} - {1'b0, wm_q}
                                  : ({1'b0, r_q} + {1'b0, size_q}) - {1'b0, wm_q};
  assign wm_inc   = {1'b0, rem} + 1'b1;
  assign wm_fix   = (wm_inc == {1'b0, size_q}) ? '0 : wm_inc[SzW-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (act_in)
            ACT_INSERT: if (size_in != '0 && probe_run) state_d = ST_MOD_H;
            ACT_QUERY: begin
              if (size_in == '0 || !probe_run) begin
                state_d = ST_RESP;
              end else begin
                state_d = ST_MOD_H;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_MOD_H: if (rem_done) state_d = ST_MOD_D;
      ST_MOD_D: if (rem_done) state_d = ST_MOD_W;
      ST_MOD_W: if (rem_done) state_d = ST_PRB_RD;
      ST_PRB_RD: state_d = ST_PRB_CHK;
      ST_PRB_CHK: begin
        if (act_q == ACT_QUERY && !bit_hit) begin
          state_d = ST_RESP;
        end else if (last_probe) begin
          state_d = (act_q == ACT_QUERY) ? ST_RESP : ST_IDLE;
        end else begin
          state_d = ST_PRB_ADJ;
        end
      end
      ST_PRB_ADJ: state_d = ST_PRB_RD;
      ST_RESP: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o   = 1'b0;
    rem_start    = 1'b0;
    rem_dividend = key_hash_i;
    st_clear     = 1'b0;
    st_rd_en     = 1'b0;
    st_wr_en     = 1'b0;
    st_wr_data   = st_rd_data | (RowW'(1) << bit_off);
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        st_clear   = in_acc && (act_in == ACT_CLEAR);
        rem_start  = in_acc && (state_d == ST_MOD_H);
      end
      ST_MOD_H: begin
        rem_start    = rem_done;
        rem_dividend = d_q;
      end
      ST_MOD_D: begin
        rem_start    = rem_done;
        rem_dividend = '1;
      end
      ST_PRB_RD:  st_rd_en = 1'b1;
      ST_PRB_CHK: st_wr_en = (act_q == ACT_INSERT);
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_RESP && state_d == ST_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          h_q    <= key_hash_i;
          d_q    <= {key_hash_i[ROT_RIGHT-1:0], key_hash_i[KEY_W-1:ROT_RIGHT]};
          act_q  <= act_in;
          size_q <= size_in;
          cnt_q  <= '0;
          hit_q  <= (size_in != '0);
        end
      end
      ST_MOD_H: if (rem_done) r_q  <= rem;
      ST_MOD_D: if (rem_done) dm_q <= rem;
      ST_MOD_W: if (rem_done) wm_q <= wm_fix;
      ST_PRB_CHK: begin
        hit_q   <= bit_hit;
        r_q     <= step_r[SzW-1:0];
        carry_q <= h_sum[KEY_W];
        h_q     <= h_sum[KEY_W-1:0];
        cnt_q   <= cnt_q + 1'b1;
      end
      ST_PRB_ADJ: if (carry_q) r_q <= wrap_r[SzW-1:0];
      ST_RESP: if (state_d == ST_IDLE) may_match_q <= hit_q;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign may_match_o = may_match_q;

  bfdh_rem_unit #(
    .SizeW(SzW)
  ) u_rem (
    .clk_i,
    .rst_ni,
    .start_i   (rem_start),
    .dividend_i(rem_dividend),
    .divisor_i (size_q),
    .busy_o    (rem_busy),
    .done_o    (rem_done),
    .rem_o     (rem)
  );

  bfdh_store #(
    .StoreBits(STORE_BITS),
    .RowLg    (RowLg),
    .RowW     (RowW),
    .Rows     (Rows),
    .RowAw    (RowAw)
  ) u_store (
    .clk_i,
    .rst_ni,
    .clear_i  (st_clear),
    .rd_en_i  (st_rd_en),
    .rd_addr_i(row_addr),
    .rd_data_o(st_rd_data),
    .wr_en_i  (st_wr_en),
    .wr_addr_i(row_addr),
    .wr_data_i(st_wr_data)
  );

  `ASSERT_NEVER(a_rem_restart, clk_i, rst_ni, rem_start && rem_busy, "remainder unit restarted while busy")
  `ASSERT_CLK(a_write_insert, clk_i, rst_ni, st_wr_en |-> (act_q == ACT_INSERT), "store written by a non-insert item")
  `ASSERT_CLK(a_probe_range, clk_i, rst_ni, (state_q == ST_PRB_RD) |-> (r_q < size_q), "probe position not below the filter size")

endmodule

// File: sim/bloom_filter_double_hash_tb.sv
module bloom_filter_double_hash_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfdh_pkg::*;

  localparam int STORE_BITS      = STORE_BITS_DEF;
  localparam int RESERVED_PROBES = MAX_PROBES + 1;
  localparam int RANDOM_ITEMS    = 1850;
  // Covers three remainder passes plus the probe steps, with margin.
  localparam int ITEM_LATENCY    = 250;
  localparam int LIMIT_CYCLES    = 3_000_000;
  localparam int KEY_POOL_DEPTH  = 64;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    bit                     is_cfg;
    cfg_reg_e               reg_sel;
    logic [CFG_DATA_W-1:0]  data;
    logic [ACTION_W-1:0]    act;
    logic [KEY_W-1:0]       key;
    bit                     typed;
    bit                     match;
  } step_row_t;

  logic                   clk_i;
  logic                   rst_ni     = 1'b0;
  logic                   cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [ACTION_W-1:0]    action_i   = '0;
  logic [KEY_W-1:0]       key_hash_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   may_match_o;

  // Shadow of the block: bit store and both registers.
  bit                     bloom_bits [STORE_BITS];
  logic [FILTER_BITS_W-1:0] size_reg   = FILTER_BITS_W'(FILTER_BITS_RST);
  logic [PROBES_W-1:0]    probes_reg = PROBES_W'(PROBES_RST);

  bit                     pending_matches [$];
  logic [KEY_W-1:0]       inserted_keys [$];
  bit                     steady = 1'b0;
  int                     mismatches = 0;
  int                     cycle_count = 0;
  bit                     expected_match;

  step_row_t directed_rows [35] = '{
    '{0, REG_FILTER_BITS, 13'd0,    ACT_QUERY,  32'h0000_0000, 1, 0},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_QUERY,  32'hFFFF_FFFF, 1, 0},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_INSERT, 32'h1234_5678, 0, 0},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_QUERY,  32'h1234_5678, 1, 1},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_UNUSED, 32'hFFFF_FFFF, 0, 0},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_CLEAR,  32'hFFFF_FFFF, 0, 0},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_QUERY,  32'h1234_5678, 1, 0},
    '{1, REG_PROBES,      13'd31,   ACT_CLEAR,  32'h0000_0000, 0, 0},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_QUERY,  32'hDEAD_BEEF, 1, 1},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_INSERT, 32'hDEAD_BEEF, 0, 0},
    '{1, REG_FILTER_BITS, 13'd0,    ACT_CLEAR,  32'h0000_0000, 0, 0},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_QUERY,  32'hDEAD_BEEF, 1, 0},
    '{1, REG_PROBES,      13'd0,    ACT_CLEAR,  32'h0000_0000, 0, 0},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_QUERY,  32'h0000_0000, 1, 0},
    '{1, REG_FILTER_BITS, 13'd4096, ACT_CLEAR,  32'h0000_0000, 0, 0},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_QUERY,  32'hCAFE_F00D, 1, 1},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_INSERT, 32'hCAFE_F00D, 0, 0},
    '{1, REG_PROBES,      13'd30,   ACT_CLEAR,  32'h0000_0000, 0, 0},
    // Neither the reserved-count insert nor the zero-probe insert set a bit.
    '{0, REG_FILTER_BITS, 13'd0,    ACT_QUERY,  32'hCAFE_F00D, 1, 0},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_INSERT, 32'hFFFF_FFFF, 0, 0},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_QUERY,  32'hFFFF_FFFF, 1, 1},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_QUERY,  32'h0000_0001, 0, 0},
    '{1, REG_FILTER_BITS, 13'h1FFF, ACT_CLEAR,  32'h0000_0000, 0, 0},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_QUERY,  32'hFFFF_FFFF, 1, 1},
    '{1, REG_FILTER_BITS, 13'd67,   ACT_CLEAR,  32'h0000_0000, 0, 0},
    '{1, REG_PROBES,      13'd1,    ACT_CLEAR,  32'h0000_0000, 0, 0},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_INSERT, 32'h8000_0000, 0, 0},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_QUERY,  32'h8000_0000, 1, 1},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_QUERY,  32'h7FFF_FFFF, 0, 0},
    '{1, REG_FILTER_BITS, 13'd1,    ACT_CLEAR,  32'h0000_0000, 0, 0},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_INSERT, 32'h0000_0005, 0, 0},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_QUERY,  32'hABCD_EF01, 1, 1},
    '{1, REG_FILTER_BITS, 13'd13,   ACT_CLEAR,  32'h0000_0000, 0, 0},
    '{1, REG_PROBES,      13'h1FE5, ACT_CLEAR,  32'h0000_0000, 0, 0},
    '{0, REG_FILTER_BITS, 13'd0,    ACT_QUERY,  32'h0000_0000, 0, 0}
  };

  bloom_filter_double_hash #(
    .STORE_BITS(STORE_BITS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .key_hash_i  (key_hash_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .may_match_o (may_match_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Applies one item to the shadow store and gives the may-match answer of a query.
  function automatic void update_and_probe(input logic [ACTION_W-1:0] act,
                                           input logic [KEY_W-1:0] key,
                                           output bit has_result, output bit hit);
    int unsigned span;
    int unsigned h;
    int unsigned step;
    int j;
    has_result = 1'b0;
    hit        = 1'b0;
    span = (size_reg > STORE_BITS) ? STORE_BITS : size_reg;
    h    = key;
    step = {key[16:0], key[31:17]};
    case (act)
      ACT_CLEAR: begin
        foreach (bloom_bits[i]) bloom_bits[i] = 1'b0;
      end
      ACT_INSERT: begin
        if (span != 0 && probes_reg <= MAX_PROBES) begin
          for (j = 0; j < probes_reg; j++) begin
            bloom_bits[h % span] = 1'b1;
            h += step;
          end
        end
      end
      ACT_QUERY: begin
        has_result = 1'b1;
        hit = (span != 0);
        if (span != 0 && probes_reg != RESERVED_PROBES) begin
          for (j = 0; j < probes_reg; j++) begin
            if (!bloom_bits[h % span]) begin
              hit = 1'b0;
              break;
            end
            h += step;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    case ($urandom_range(0, 15))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] key,
                           input bit typed, input bit typed_match);
    int gap;
    bit has_result;
    bit hit;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    key_hash_i <= key;
    do @(posedge clk_i); while (!in_ready_o);
    update_and_probe(act, key, has_result, hit);
    if (has_result) pending_matches = {pending_matches, (typed ? typed_match : hit)};
  endtask

  task automatic await_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_matches.size() != 0) @(posedge clk_i);
  endtask

  // An insert gives no result, so the block may still be probing after the last answer.
  task automatic settle_block();
    await_results();
    repeat (ITEM_LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e sel, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (sel)
      REG_FILTER_BITS: size_reg   = data[FILTER_BITS_W-1:0];
      REG_PROBES:      probes_reg = data[PROBES_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_matches.size() == 0) begin
        mismatches++;
        $display("%0t: may_match expected none, got %0b", $time, may_match_o);
      end else begin
        expected_match = pending_matches.pop_front();
        if (may_match_o !== expected_match) begin
          mismatches++;
          $display("%0t: may_match expected %0b, got %0b", $time, expected_match,
                   may_match_o);
        end
      end
    end
  end

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    int items_sent;
    int phase_len;
    int r;
    logic [KEY_W-1:0] key;
    logic [CFG_DATA_W-1:0] size_cfg;
    logic [PROBES_W-1:0] probe_cfg;
    items_sent = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle_block();
        write_reg(directed_rows[i].reg_sel, directed_rows[i].data);
      end else begin
        send_item(directed_rows[i].act, directed_rows[i].key, directed_rows[i].typed,
                  directed_rows[i].match);
      end
    end

    while (items_sent < RANDOM_ITEMS) begin
      settle_block();
      case ($urandom_range(0, 11))
        0:       size_cfg = 13'd0;
        1:       size_cfg = 13'd64;
        2:       size_cfg = 13'd4096;
        3:       size_cfg = CFG_DATA_W'($urandom_range(4097, 8191));
        4:       size_cfg = CFG_DATA_W'($urandom_range(1, 63));
        5, 6:    size_cfg = CFG_DATA_W'(8 * $urandom_range(8, 512));
        default: size_cfg = CFG_DATA_W'($urandom_range(64, 4096));
      endcase
      case ($urandom_range(0, 9))
        0:       probe_cfg = 5'd0;
        1:       probe_cfg = PROBES_W'(RESERVED_PROBES);
        2:       probe_cfg = PROBES_W'(MAX_PROBES);
        3:       probe_cfg = 5'd1;
        default: probe_cfg = PROBES_W'($urandom_range(1, MAX_PROBES));
      endcase
      write_reg(REG_FILTER_BITS, size_cfg);
      // Bits above the probe count are ignored by the register.
      write_reg(REG_PROBES, {8'($urandom_range(0, 255)), probe_cfg});
      steady = ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(80, 200);

      for (int n = 0; n < phase_len && items_sent < RANDOM_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          inserted_keys.delete();
          send_item(ACT_CLEAR, random_key(), 1'b0, 1'b0);
          items_sent++;
        end else if (r < 5) begin
          send_item(ACT_UNUSED, random_key(), 1'b0, 1'b0);
        end else if (r < 40) begin
          key = random_key();
          inserted_keys = {inserted_keys, key};
          if (inserted_keys.size() > KEY_POOL_DEPTH) void'(inserted_keys.pop_front());
          send_item(ACT_INSERT, key, 1'b0, 1'b0);
          items_sent++;
        end else begin
          if (r < 88 && inserted_keys.size() != 0) begin
            key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
            // A near miss: one bit of a stored key flipped.
            if (r >= 78) key[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
          end else begin
            key = random_key();
          end
          send_item(ACT_QUERY, key, 1'b0, 1'b0);
          items_sent++;
        end
        if ($urandom_range(0, 99) == 0) await_results();
      end
    end

    await_results();
    repeat (ITEM_LATENCY) @(posedge clk_i);
    if (pending_matches.size() != 0) begin
      mismatches++;
      $display("%0t: %0d may_match items expected, 0 received", $time,
               pending_matches.size());
    end
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
